/* hdl/lzss_pkg.sv */
package lzss_pkg;

    // Field and counter widths fixed by the stream format.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 24;
    localparam int DIST_W  = 12;
    localparam int LEN_W   = 5;
    localparam int BITS_W  = 4;

    // A match length is coded as length minus two.
    localparam logic [LEN_W-1:0] LEN_BIAS = 5'd2;

    // A flag byte governs eight tokens.
    localparam logic [BITS_W-1:0] FLAG_COUNT = 4'd8;

    // The total length register comes out of reset at its largest value.
    localparam logic [COUNT_W-1:0] TOTAL_LEN_RST = 24'hFF_FFFF;

    // Top-level sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_COPY = 2'b10
    } state_t;

endpackage

/* hdl/lzss_win_ram.sv */
module lzss_win_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [lzss_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [lzss_pkg::BYTE_W-1:0] rdata
);
    import lzss_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/lzss_stream_decoder_core.sv */
// A literal passes through the read stage and the output register; a match byte is
// read from the window in the copy state, then takes the same path. A flag byte or
// first token byte gives no result. No new byte is taken while one sits in the read
// stage or a match is copying; a match streams one byte per cycle from the window
// port while the output is not stalled. Reset clears all control state, then sweeps
// the window to zero with in_ready low; configuration writes are taken throughout.
module lzss_stream_decoder_core #(
    parameter int WINDOW_DEPTH = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lzss_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          stream_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lzss_pkg::BYTE_W-1:0]    out_byte,
    output logic                          run_last,
    input  logic                          cfg_we,
    input  logic [lzss_pkg::COUNT_W-1:0]   cfg_wdata
);
    import lzss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    state_t              state_reg;
    state_t              state_next;

    logic                clr_active_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [COUNT_W-1:0]  total_length_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0]   flag_bits_reg;
    logic [BITS_W-1:0]   bits_left_reg;
    logic [BYTE_W-1:0]   token_low_reg;
    logic                token_phase_reg;
    logic [AW-1:0]       src_reg;
    logic [LEN_W-1:0]    remain_reg;

    logic                stage_valid_reg;
    logic                stage_lit_reg;
    logic [BYTE_W-1:0]   stage_lit_data_reg;
    logic                stage_last_reg;
    logic                stage_fwd_reg;
    logic [BYTE_W-1:0]   fwd_data_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                run_last_reg;

    logic                in_accept;
    logic                phase_eff;
    logic [BITS_W-1:0]   bits_eff;
    logic [BYTE_W-1:0]   flags_eff;
    logic                is_token_hi;
    logic                is_flag;
    logic                is_lit;
    logic                is_low;
    logic [DIST_W-1:0]   tok_dist;
    logic [LEN_W-1:0]    tok_len;

    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   stage_data;
    logic                limit_hit;
    logic                out_free;
    logic                consume;
    logic                emit;
    logic                emit_last;
    logic                issue;
    logic                fwd_hit;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;

    // Input handshake: one item at a time, only when no byte is in flight.
    assign in_ready  = (state_reg == S_IDLE) && !clr_active_reg && !stage_valid_reg;
    assign in_accept = in_valid && in_ready;

    // Parse state as seen by this item, after an optional stream restart.
    assign phase_eff = token_phase_reg && !stream_start;
    assign bits_eff  = stream_start ? '0 : bits_left_reg;
    assign flags_eff = stream_start ? '0 : flag_bits_reg;

    // Decode the item's role in the stream.
    assign is_token_hi = in_accept && phase_eff;
    assign is_flag     = in_accept && !phase_eff && (bits_eff == '0);
    assign is_lit      = in_accept && !phase_eff && (bits_eff != '0) && !flags_eff[0];
    assign is_low      = in_accept && !phase_eff && (bits_eff != '0) && flags_eff[0];

    // Match token fields: low 12 bits distance, top nibble length minus two.
    assign tok_dist = {in_byte[3:0], token_low_reg};
    assign tok_len  = LEN_W'(in_byte[7:4]) + LEN_BIAS;

    // The byte at the output side of the read stage.
    assign stage_data = stage_lit_reg ? stage_lit_data_reg :
                        (stage_fwd_reg ? fwd_data_reg : rd_data);

    // Bytes past the total length are dropped without waiting for the output.
    assign limit_hit = count_reg >= total_length_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign consume   = stage_valid_reg && (limit_hit || out_free);
    assign emit      = consume && !limit_hit;
    // Once the limit is reached every later byte drops, so the byte that reaches
    // it closes the run.
    assign emit_last = stage_last_reg || ((count_reg + COUNT_W'(1)) == total_length_reg);

    // A copy read goes out whenever the read stage frees up this cycle.
    assign issue = (state_reg == S_COPY) && (!stage_valid_reg || consume);

    // The read of the byte just being written sees the old memory contents.
    assign fwd_hit = emit && (src_reg == count_reg[AW-1:0]);

    // Window write port: clearing sweep, otherwise emitted bytes.
    assign ram_we    = clr_active_reg || emit;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : count_reg[AW-1:0];
    assign ram_wdata = clr_active_reg ? '0 : stage_data;

    lzss_win_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_win_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (src_reg),
        .rdata (rd_data)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (is_token_hi)
                begin
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (issue && (remain_reg == LEN_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            total_length_reg <= TOTAL_LEN_RST;
            count_reg        <= '0;
            flag_bits_reg    <= '0;
            bits_left_reg    <= '0;
            token_low_reg    <= '0;
            token_phase_reg  <= 1'b0;
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Clearing sweep after reset.
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (cfg_we)
            begin
                total_length_reg <= cfg_wdata;
            end

            // Output count: restart or advance per emitted byte.
            if (in_accept && stream_start)
            begin
                count_reg <= '0;
            end
            else if (emit)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end

            // Parse state.
            if (in_accept)
            begin
                flag_bits_reg   <= flags_eff;
                bits_left_reg   <= bits_eff;
                token_low_reg   <= stream_start ? '0 : token_low_reg;
                token_phase_reg <= phase_eff;
                if (is_flag)
                begin
                    flag_bits_reg <= in_byte;
                    bits_left_reg <= FLAG_COUNT;
                end
                else if (is_lit || is_token_hi)
                begin
                    flag_bits_reg   <= flags_eff >> 1;
                    bits_left_reg   <= bits_eff - BITS_W'(1);
                    token_phase_reg <= 1'b0;
                end
                else if (is_low)
                begin
                    token_low_reg   <= in_byte;
                    token_phase_reg <= 1'b1;
                end
            end

            // Read stage occupancy.
            if (is_lit || issue)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                stage_valid_reg <= 1'b0;
            end

            // Output register.
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (is_token_hi)
        begin
            src_reg    <= count_reg[AW-1:0] - AW'(tok_dist);
            remain_reg <= tok_len;
        end
        else if (issue)
        begin
            src_reg    <= src_reg + AW'(1);
            remain_reg <= remain_reg - LEN_W'(1);
        end

        if (is_lit)
        begin
            stage_lit_reg      <= 1'b1;
            stage_lit_data_reg <= in_byte;
            stage_last_reg     <= 1'b1;
            stage_fwd_reg      <= 1'b0;
        end
        else if (issue)
        begin
            stage_lit_reg  <= 1'b0;
            stage_last_reg <= (remain_reg == LEN_W'(1));
            stage_fwd_reg  <= fwd_hit;
            fwd_data_reg   <= stage_data;
        end

        if (emit)
        begin
            out_byte_reg <= stage_data;
            run_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

/* hdl/lzss_sva.sv */
module lzss_sva (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lzss_pkg::BYTE_W-1:0]    out_byte,
    input logic                          run_last
);
    import lzss_pkg::*;

    // A waiting result item holds its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("output item changed while stalled");

    // The window sweep keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input ready during window clearing");

    // No result can come out before any item was taken.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result item right after reset");

    // No result item appears while the window is still being cleared.
    a_not_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !out_valid)
        else $error("result item during window clearing");

endmodule

bind lzss_stream_decoder_core lzss_sva u_lzss_sva (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
);
